FILE: rtl/tlp_pkg.sv
// Shared types, constants and lamp decode for the traffic light controller.
// No dependencies; the module files refer to it by scoped names.
package tlp_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int DUR_W           = 16;
    localparam int LIMIT_W         = 4;
    localparam int PHASE_W         = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    typedef enum logic [PHASE_W-1:0] {
        PH_MAIN_GREEN  = 4'd0,
        PH_MAIN_WAIT   = 4'd1,
        PH_YELLOW_WALK = 4'd2,
        PH_YELLOW_SIDE = 4'd3,
        PH_WALK        = 4'd4,
        PH_BLINK_ON    = 4'd5,
        PH_BLINK_OFF   = 4'd6,
        PH_SIDE_GREEN  = 4'd7,
        PH_SIDE_YELLOW = 4'd8
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAIN_GREEN  = 3'd0,
        CFG_YELLOW      = 3'd1,
        CFG_WALK        = 3'd2,
        CFG_BLINK_HALF  = 3'd3,
        CFG_SIDE_GREEN  = 3'd4,
        CFG_BLINK_LIMIT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DUR_W-1:0]   main_green_ticks;
        logic [DUR_W-1:0]   yellow_ticks;
        logic [DUR_W-1:0]   walk_ticks;
        logic [DUR_W-1:0]   blink_half_ticks;
        logic [DUR_W-1:0]   side_green_ticks;
        logic [LIMIT_W-1:0] blink_half_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        main_green_ticks: 16'd10000,
        yellow_ticks:     16'd2000,
        walk_ticks:       16'd3000,
        blink_half_ticks: 16'd500,
        side_green_ticks: 16'd6000,
        blink_half_limit: 4'd4
    };

    typedef struct packed {
        logic ped_request;
        logic side_car;
    } t_req;

    typedef struct packed {
        logic               main_red;
        logic               main_yellow;
        logic               main_green;
        logic               side_red;
        logic               side_yellow;
        logic               side_green;
        logic               walk_red;
        logic               walk_green;
        logic [PHASE_W-1:0] phase;
    } t_res;

    function automatic t_res lamps(t_phase p);
        t_res r;
        r.main_red    = (p >= PH_WALK);
        r.main_yellow = (p == PH_YELLOW_WALK) || (p == PH_YELLOW_SIDE);
        r.main_green  = (p <= PH_MAIN_WAIT);
        r.side_red    = (p <= PH_BLINK_OFF);
        r.side_yellow = (p == PH_SIDE_YELLOW);
        r.side_green  = (p == PH_SIDE_GREEN);
        r.walk_red    = (p != PH_WALK) && (p != PH_BLINK_OFF);
        r.walk_green  = (p == PH_WALK);
        r.phase       = p;
        return r;
    endfunction

endpackage

FILE: rtl/tlp_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Payload types come from tlp_pkg at the point of instantiation.
interface tlp_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/traffic_light_with_pedestrian_controller.sv
// Top level of the traffic light controller with pedestrian crossing.
// Depends on tlp_pkg, tlp_stream_if, tlp_cfg, tlp_core and tlp_out.
//
//  port        dir   protocol      carries
//  i_req       in    valid/ready   one tick: ped_request, side_car
//  o_res       out   valid/ready   eight lamp drives and phase after the tick
//  i_cfg_*     in    write enable  register index 0..5 and 16-bit data
//
// One transaction per cycle while o_res is not stalled; the result is valid in the cycle after acceptance.
// The phase, timer and blink counter update in the accepting cycle.
// i_req.ready stays high while the result register is empty or being taken.
// Synchronous active-low reset restores the default durations and phase 0.
module traffic_light_with_pedestrian_controller #(
    parameter int TIMER_WIDTH = tlp_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tlp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    tlp_stream_if.sink                      i_req,
    tlp_stream_if.source                    o_res
);

    tlp_pkg::t_cfg   cfg;
    tlp_pkg::t_phase next_phase;
    logic            free;
    logic            step;

    assign i_req.ready = free;
    assign step        = i_req.valid && free;

    tlp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tlp_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_req        (i_req.payload),
        .i_cfg        (cfg),
        .o_next_phase (next_phase)
    );

    tlp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_phase (next_phase),
        .o_free  (free),
        .o_res   (o_res)
    );

endmodule

FILE: rtl/tlp_cfg.sv
// Configuration register file for phase durations and blink limit.
// Depends on tlp_pkg.
module tlp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tlp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tlp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output tlp_pkg::t_cfg                      o_cfg
);

    tlp_pkg::t_cfg r_cfg;
    tlp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlp_pkg::CFG_MAIN_GREEN:  n_cfg.main_green_ticks = i_cfg_wdata;
                tlp_pkg::CFG_YELLOW:      n_cfg.yellow_ticks     = i_cfg_wdata;
                tlp_pkg::CFG_WALK:        n_cfg.walk_ticks       = i_cfg_wdata;
                tlp_pkg::CFG_BLINK_HALF:  n_cfg.blink_half_ticks = i_cfg_wdata;
                tlp_pkg::CFG_SIDE_GREEN:  n_cfg.side_green_ticks = i_cfg_wdata;
                tlp_pkg::CFG_BLINK_LIMIT: begin
                    n_cfg.blink_half_limit = i_cfg_wdata[tlp_pkg::LIMIT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tlp_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/tlp_core.sv
// Phase sequencer: phase, tick timer, blink counter and served flag.
// Steps once per accepted transaction. Depends on tlp_pkg.
module tlp_core #(
    parameter int TIMER_WIDTH = tlp_pkg::TIMER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  tlp_pkg::t_req    i_req,
    input  tlp_pkg::t_cfg    i_cfg,
    output tlp_pkg::t_phase  o_next_phase
);

    localparam int CMP_W = (TIMER_WIDTH > tlp_pkg::DUR_W) ? TIMER_WIDTH : tlp_pkg::DUR_W;

    tlp_pkg::t_phase               r_phase, n_phase;
    logic [TIMER_WIDTH-1:0]        r_tick, n_tick;
    logic [tlp_pkg::LIMIT_W-1:0]   r_blink, n_blink;
    logic                          r_served, n_served;

    logic [tlp_pkg::DUR_W-1:0]     dur;
    logic [TIMER_WIDTH-1:0]        t_next;
    logic                          done;
    logic [tlp_pkg::LIMIT_W-1:0]   blink_inc;

    always_comb begin
        unique case (r_phase) inside
            tlp_pkg::PH_MAIN_GREEN:  dur = i_cfg.main_green_ticks;
            tlp_pkg::PH_YELLOW_WALK, tlp_pkg::PH_YELLOW_SIDE,
            tlp_pkg::PH_SIDE_YELLOW: dur = i_cfg.yellow_ticks;
            tlp_pkg::PH_WALK:        dur = i_cfg.walk_ticks;
            tlp_pkg::PH_BLINK_ON,
            tlp_pkg::PH_BLINK_OFF:   dur = i_cfg.blink_half_ticks;
            tlp_pkg::PH_SIDE_GREEN:  dur = i_cfg.side_green_ticks;
            default:                 dur = '0;
        endcase
    end

    // saturating tick count
    assign t_next    = (&r_tick) ? r_tick : r_tick + 1'b1;
    assign done      = (CMP_W'(t_next) >= CMP_W'(dur)) || (&t_next);
    assign blink_inc = (&r_blink) ? r_blink : r_blink + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_blink  = r_blink;
        n_served = r_served;
        unique case (r_phase)
            tlp_pkg::PH_MAIN_GREEN: begin
                n_tick = t_next;
                if (done) begin
                    n_phase = tlp_pkg::PH_MAIN_WAIT;
                    n_tick  = '0;
                end
            end
            tlp_pkg::PH_MAIN_WAIT: begin
                if (i_req.ped_request) begin
                    n_phase = tlp_pkg::PH_YELLOW_WALK;
                    n_tick  = '0;
                end else if (i_req.side_car) begin
                    n_phase = tlp_pkg::PH_YELLOW_SIDE;
                    n_tick  = '0;
                end
            end
            tlp_pkg::PH_YELLOW_WALK: begin
                n_tick = t_next;
                if (done) begin
                    n_phase = tlp_pkg::PH_WALK;
                    n_tick  = '0;
                end
            end
            tlp_pkg::PH_YELLOW_SIDE: begin
                n_tick = t_next;
                if (done) begin
                    n_phase = tlp_pkg::PH_SIDE_GREEN;
                    n_tick  = '0;
                end
            end
            tlp_pkg::PH_WALK: begin
                n_tick = t_next;
                if (done) begin
                    n_phase = tlp_pkg::PH_BLINK_ON;
                    n_tick  = '0;
                end
            end
            tlp_pkg::PH_BLINK_ON: begin
                n_tick = t_next;
                if (done) begin
                    n_blink = blink_inc;
                    n_phase = tlp_pkg::PH_BLINK_OFF;
                    n_tick  = '0;
                end
            end
            tlp_pkg::PH_BLINK_OFF: begin
                n_tick = t_next;
                if (done) begin
                    n_tick = '0;
                    if (blink_inc >= i_cfg.blink_half_limit) begin
                        n_blink = '0;
                        n_phase = i_req.side_car ? tlp_pkg::PH_SIDE_GREEN
                                                 : tlp_pkg::PH_MAIN_GREEN;
                    end else begin
                        n_blink = blink_inc;
                        n_phase = tlp_pkg::PH_BLINK_ON;
                    end
                end
            end
            tlp_pkg::PH_SIDE_GREEN: begin
                n_tick = t_next;
                if (done) begin
                    n_phase = tlp_pkg::PH_SIDE_YELLOW;
                    n_tick  = '0;
                end
            end
            tlp_pkg::PH_SIDE_YELLOW: begin
                n_tick = t_next;
                if (done) begin
                    n_phase = (i_req.ped_request && !r_served) ? tlp_pkg::PH_WALK
                                                               : tlp_pkg::PH_MAIN_GREEN;
                    n_tick  = '0;
                end
            end
            default: begin
                n_phase = tlp_pkg::PH_MAIN_GREEN;
                n_tick  = '0;
            end
        endcase
        // served flag follows the phase being entered or held
        if (n_phase == tlp_pkg::PH_MAIN_GREEN) n_served = 1'b0;
        if (n_phase == tlp_pkg::PH_WALK)       n_served = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tlp_pkg::PH_MAIN_GREEN;
            r_tick   <= '0;
            r_blink  <= '0;
            r_served <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_blink  <= n_blink;
            r_served <= n_served;
        end
    end

    assign o_next_phase = n_phase;

`ifndef SYNTHESIS
    a_blink_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != tlp_pkg::PH_BLINK_ON && r_phase != tlp_pkg::PH_BLINK_OFF)
        |-> (r_blink == '0))
        else $error("blink count nonzero outside blink phases");

    a_wait_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tlp_pkg::PH_MAIN_WAIT) |-> (r_tick == '0))
        else $error("timer running in wait phase");

    a_blink_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tlp_pkg::PH_BLINK_ON || r_phase == tlp_pkg::PH_BLINK_OFF)
        |-> r_served)
        else $error("blink phase without walk served");

    a_phase_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_phase != r_phase) |=> (r_tick == '0))
        else $error("timer not cleared on phase change");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_tick))
        else $error("state moved without a transaction");
`endif

endmodule

FILE: rtl/tlp_out.sv
// Result register: lamp decode of the new phase and output handshake.
// Depends on tlp_pkg and tlp_stream_if.
module tlp_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tlp_pkg::t_phase  i_phase,
    output logic             o_free,
    tlp_stream_if.source     o_res
);

    logic          r_valid;
    tlp_pkg::t_res r_payload;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_payload <= tlp_pkg::lamps(i_phase);
        end
    end

    assign o_res.valid   = r_valid;
    assign o_res.payload = r_payload;

endmodule
